// ----- design/sfpq_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpq_pkg
// Shared types and codes of the four-level stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpq_pkg;

    // Field widths
    localparam int TAG_W    = 16;
    localparam int COND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int PRIO_W   = 3;
    localparam int ROOM_W   = 2;
    localparam int LEVELS   = 4;

    // Transaction kinds
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_SERVE = 1'b1;

    // Condition codes, most urgent first
    localparam logic [COND_W-1:0] COND_CRITICAL = 2'd0;
    localparam logic [COND_W-1:0] COND_SERIOUS  = 2'd1;
    localparam logic [COND_W-1:0] COND_FAIR     = 2'd2;
    localparam logic [COND_W-1:0] COND_OTHER    = 2'd3;

    // Priorities
    localparam logic [PRIO_W-1:0] PRIO_NONE = 3'd0;
    localparam logic [PRIO_W-1:0] PRIO_1    = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_2    = 3'd2;
    localparam logic [PRIO_W-1:0] PRIO_3    = 3'd3;
    localparam logic [PRIO_W-1:0] PRIO_4    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SERVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Room codes
    localparam logic [ROOM_W-1:0] ROOM_EMERGENCY    = 2'd0;
    localparam logic [ROOM_W-1:0] ROOM_EXAMINATION  = 2'd1;
    localparam logic [ROOM_W-1:0] ROOM_CONSULTATION = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_SERVE
    } t_state;

    // Priority of a condition code
    function automatic logic [PRIO_W-1:0] prio_of(input logic [COND_W-1:0] cond);
        logic [PRIO_W-1:0] p;
        case (cond)
            COND_CRITICAL: p = PRIO_4;
            COND_SERIOUS:  p = PRIO_3;
            COND_FAIR:     p = PRIO_2;
            default:       p = PRIO_1;
        endcase
        return p;
    endfunction

    // Room for a condition code
    function automatic logic [ROOM_W-1:0] room_of(input logic [COND_W-1:0] cond);
        logic [ROOM_W-1:0] r;
        case (cond)
            COND_CRITICAL: r = ROOM_EMERGENCY;
            COND_SERIOUS:  r = ROOM_EXAMINATION;
            default:       r = ROOM_CONSULTATION;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/stable_four_level_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_four_level_priority_queue
// Bounded four-level priority queue, first-in-first-out within each level.
// ----------------------------------------------------------------------------
// An add transaction leaves busy low, and the next transaction can start in
// the following cycle. A serve transaction raises busy in the cycle after it
// is taken, while the registered read of the tag memory completes. Every
// transaction yields exactly one result, shown on the result ports for one
// cycle with o_done high, in the cycle after start is taken (a serve result
// coincides with its busy cycle). The receiver cannot stall the block, so
// o_done must be sampled every cycle. The tag memory holds
// one region of CAPACITY entries per level (4 x 2^ceil(log2(CAPACITY))
// words of 16 bits); the total number of waiting entries is bounded by
// CAPACITY. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_four_level_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               i_func,
    input  wire  [sfpq_pkg::COND_W-1:0]       i_condition,
    input  wire  [sfpq_pkg::TAG_W-1:0]        i_patient_tag,
    output logic                              o_done,
    output logic [sfpq_pkg::STATUS_W-1:0]     o_status,
    output logic [sfpq_pkg::TAG_W-1:0]        o_served_tag,
    output logic [sfpq_pkg::PRIO_W-1:0]       o_served_priority,
    output logic [sfpq_pkg::ROOM_W-1:0]       o_room
);

    import sfpq_pkg::*;

    localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = PW + COND_W;
    localparam int DEPTH = LEVELS << PW;

    // State and pointers
    t_state              r_state, n_state;
    logic [PW-1:0]       r_head [LEVELS];
    logic [PW-1:0]       r_tail [LEVELS];
    logic [CW-1:0]       r_lvl_cnt [LEVELS];
    logic [CW-1:0]       r_total;

    // Result registers
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [PRIO_W-1:0]   r_prio;
    logic [ROOM_W-1:0]   r_room;

    // Tag memory
    logic [TAG_W-1:0]    mem [DEPTH];
    logic [TAG_W-1:0]    r_rd_data;

    logic                accept;
    logic                do_add;
    logic                do_serve;
    logic                full;
    logic                any_waiting;
    logic [COND_W-1:0]   sel_lvl;
    logic [COND_W-1:0]   add_lvl;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(CAPACITY - 1)) ? '0 : p + PW'(1);
    endfunction

    // Decode and level select
    always_comb begin
        accept      = start && (r_state == S_IDLE);
        full        = (r_total >= CW'(CAPACITY));
        any_waiting = (r_total != '0);
        do_add      = accept && (i_func == FUNC_ADD) && !full;
        do_serve    = accept && (i_func == FUNC_SERVE) && any_waiting;
        add_lvl     = i_condition;
        // most urgent non-empty level; level 0 is critical
        sel_lvl = COND_OTHER;
        if (r_lvl_cnt[COND_FAIR] != '0)     sel_lvl = COND_FAIR;
        if (r_lvl_cnt[COND_SERIOUS] != '0)  sel_lvl = COND_SERIOUS;
        if (r_lvl_cnt[COND_CRITICAL] != '0) sel_lvl = COND_CRITICAL;
        wr_addr = {add_lvl, r_tail[add_lvl]};
        rd_addr = {sel_lvl, r_head[sel_lvl]};
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (do_serve) n_state = S_SERVE;
            end
            S_SERVE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        busy              = (r_state == S_SERVE);
        o_done            = r_done;
        o_status          = r_status;
        o_served_priority = r_prio;
        o_room            = r_room;
        o_served_tag      = (r_status == ST_SERVED) ? r_rd_data : '0;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Level pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]    <= '0;
                r_tail[l]    <= '0;
                r_lvl_cnt[l] <= '0;
            end
        end else if (do_add) begin
            r_tail[add_lvl]    <= ptr_inc(r_tail[add_lvl]);
            r_lvl_cnt[add_lvl] <= r_lvl_cnt[add_lvl] + CW'(1);
            r_total            <= r_total + CW'(1);
        end else if (do_serve) begin
            r_head[sel_lvl]    <= ptr_inc(r_head[sel_lvl]);
            r_lvl_cnt[sel_lvl] <= r_lvl_cnt[sel_lvl] - CW'(1);
            r_total            <= r_total - CW'(1);
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= accept;
        end
        if (accept) begin
            r_prio <= PRIO_NONE;
            r_room <= ROOM_EMERGENCY;
            if (i_func == FUNC_ADD) begin
                r_status <= full ? ST_FULL : ST_ADDED;
            end else if (!any_waiting) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_SERVED;
                r_prio   <= prio_of(sel_lvl);
                r_room   <= room_of(sel_lvl);
            end
        end
    end

    // Tag memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (do_add) begin
            mem[wr_addr] <= i_patient_tag;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
